FILE: rtl/core/base64_stream_decoder_core_defines.svh
// assertion macros shared by the base64 stream decoder rtl
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// check on every clock, held off while reset is asserted
`define B64D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock, reset included
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define B64D_ASSERT(label, prop, msg)
`define B64D_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/core/b64d_pkg.sv
// types, constants and the character map of the base64 stream decoder
package b64d_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_BYTE         = 3'd0;
    localparam t_status ST_INVALID      = 3'd1;
    localparam t_status ST_PADDING      = 3'd2;
    localparam t_status ST_COMMENT_LONG = 3'd3;
    localparam t_status ST_COMMENT_DASH = 3'd4;
    localparam t_status ST_TRUNCATED    = 3'd5;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_DIG_0   = 8'h30;
    localparam logic [7:0] CH_DIG_9   = 8'h39;

    // bit 6 set means the character is not part of the alphabet
    localparam logic [6:0] NOT_SEXTET = 7'd64;
    localparam logic [6:0] SEXTET_PLUS  = 7'd62;
    localparam logic [6:0] SEXTET_SLASH = 7'd63;

    localparam logic [7:0] B64D_LIMIT_RESET = 8'd75;
    localparam int         B64D_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        t_status    status;
        logic       last_of_run;
    } t_out_word;

    // all results of one character: up to three bytes, or one error word
    typedef struct packed {
        logic [1:0]      count;
        t_status         status;
        logic [2:0][7:0] bytes;
    } t_pkt;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = NOT_SEXTET;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = 7'(c - CH_UP_A);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = 7'(c - CH_LO_A + 8'd26);
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            v = 7'(c - CH_DIG_0 + 8'd52);
        end else if (c == CH_PLUS) begin
            v = SEXTET_PLUS;
        end else if (c == CH_SLASH) begin
            v = SEXTET_SLASH;
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/b64d_front.sv
// front end: accepts characters, tracks quartet and comment state, builds result packets
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_valid,
    input  b64d_pkg::t_in_word i_word,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output b64d_pkg::t_pkt   o_pkt
);
    import b64d_pkg::*;

    logic [7:0]  r_limit;
    logic [1:0]  r_pos,       n_pos;
    logic [17:0] r_acc,       n_acc;
    logic [1:0]  r_pad,       n_pad;
    logic        r_in_cmt,    n_in_cmt;
    logic [7:0]  r_cmt_cnt,   n_cmt_cnt;
    logic        r_error,     n_error;
    logic        r_done,      n_done;

    logic        accept;
    logic [7:0]  c;
    logic [6:0]  sx;
    logic [8:0]  cmt_next;
    logic [23:0] full;
    logic        fail_en;
    t_status     fail_st;
    t_pkt        pkt;

    assign o_stall  = i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign c        = i_word.char_in;
    assign sx       = sextet_of(c);
    assign cmt_next = {1'b0, r_cmt_cnt} + 9'd1;
    assign full     = {r_acc, sx[5:0]};

    always_comb begin
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_pad     = r_pad;
        n_in_cmt  = r_in_cmt;
        n_cmt_cnt = r_cmt_cnt;
        n_error   = r_error;
        n_done    = r_done;
        fail_en   = 1'b0;
        fail_st   = ST_BYTE;
        pkt       = '0;

        if (!r_error) begin
            if (r_done) begin
                if (r_pad != 2'd0 && c != CH_NEWLINE) begin
                    fail_en = 1'b1;
                    fail_st = ST_PADDING;
                end
            end else if (r_in_cmt) begin
                if (c == CH_NEWLINE) begin
                    n_in_cmt  = 1'b0;
                    n_cmt_cnt = '0;
                end else if (c == CH_DASH) begin
                    fail_en = 1'b1;
                    fail_st = ST_COMMENT_DASH;
                end else begin
                    if (cmt_next > {1'b0, r_limit}) begin
                        fail_en = 1'b1;
                        fail_st = ST_COMMENT_LONG;
                    end
                    n_cmt_cnt = cmt_next[8] ? 8'hFF : cmt_next[7:0];
                end
            end else if (c == CH_NEWLINE) begin
                // skipped
            end else if (c == CH_DASH) begin
                if (r_pos == 2'd0) begin
                    n_in_cmt  = 1'b1;
                    n_cmt_cnt = '0;
                end else begin
                    fail_en = 1'b1;
                    fail_st = ST_INVALID;
                end
            end else if (c == CH_PAD) begin
                if (r_pos < 2'd2) begin
                    fail_en = 1'b1;
                    fail_st = ST_PADDING;
                end else if (r_pos == 2'd2) begin
                    n_pad = 2'd1;
                    n_pos = 2'd3;
                end else if (r_pad != 2'd0) begin
                    // two pads: twelve bits held
                    pkt.count    = 2'd1;
                    pkt.bytes[0] = r_acc[11:4];
                    n_pos  = '0;
                    n_acc  = '0;
                    n_pad  = 2'd2;
                    n_done = 1'b1;
                end else begin
                    // one pad: eighteen bits held
                    pkt.count    = 2'd2;
                    pkt.bytes[0] = r_acc[17:10];
                    pkt.bytes[1] = r_acc[9:2];
                    n_pos  = '0;
                    n_acc  = '0;
                    n_pad  = 2'd1;
                    n_done = 1'b1;
                end
            end else if (sx[6]) begin
                fail_en = 1'b1;
                fail_st = ST_INVALID;
            end else if (r_pad != 2'd0) begin
                fail_en = 1'b1;
                fail_st = ST_PADDING;
            end else if (r_pos < 2'd3) begin
                n_acc = full[17:0];
                n_pos = r_pos + 2'd1;
            end else begin
                pkt.count    = 2'd3;
                pkt.bytes[0] = full[23:16];
                pkt.bytes[1] = full[15:8];
                pkt.bytes[2] = full[7:0];
                n_pos = '0;
                n_acc = '0;
                n_pad = '0;
            end

            if (fail_en) begin
                pkt.count  = 2'd1;
                pkt.status = fail_st;
                n_error    = 1'b1;
            end

            if (i_word.end_of_stream && !n_error && !n_done) begin
                n_in_cmt  = 1'b0;
                n_cmt_cnt = '0;
                n_done    = 1'b1;
                if (n_pos != 2'd0) begin
                    pkt.count  = 2'd1;
                    pkt.status = ST_TRUNCATED;
                    pkt.bytes  = '0;
                    n_error    = 1'b1;
                end
            end
        end
    end

    assign o_push = accept && (pkt.count != 2'd0);
    assign o_pkt  = pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= B64D_LIMIT_RESET;
            r_pos     <= '0;
            r_acc     <= '0;
            r_pad     <= '0;
            r_in_cmt  <= 1'b0;
            r_cmt_cnt <= '0;
            r_error   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos     <= n_pos;
                r_acc     <= n_acc;
                r_pad     <= n_pad;
                r_in_cmt  <= n_in_cmt;
                r_cmt_cnt <= n_cmt_cnt;
                r_error   <= n_error;
                r_done    <= n_done;
            end
        end
    end

endmodule

FILE: rtl/core/b64d_queue.sv
// short packet queue between the front end and the back end
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_pkt i_pkt,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b64d_pkg::t_pkt o_head
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/b64d_back.sv
// back end: unpacks queued packets into output words through the output register
`include "base64_stream_decoder_core_defines.svh"

module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b64d_pkg::t_pkt    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output b64d_pkg::t_out_word o_word
);
    import b64d_pkg::*;

    logic      r_valid;
    t_out_word r_word, n_word;
    logic [1:0] r_idx;
    logic      load;
    logic      last;

    assign load = i_q_valid && (!r_valid || !i_stall);
    assign last = (r_idx == 2'(i_head.count - 2'd1));
    assign o_pop = load && last;

    always_comb begin
        n_word.data_byte   = i_head.bytes[r_idx];
        n_word.status      = i_head.status;
        n_word.last_of_run = last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    // an error is always a packet of its own
    `B64D_ASSERT(a_err_single, r_valid && r_word.status != ST_BYTE |-> r_word.last_of_run, "error word not last of run")
    `B64D_ASSERT(a_status_range, r_valid |-> r_word.status <= ST_TRUNCATED, "status code out of range")
    // mid-packet means the packet is still at the queue head
    `B64D_ASSERT(a_idx_head, r_idx != 2'd0 |-> i_q_valid, "unpack index set with empty queue")
    `B64D_ASSERT(a_idx_bound, i_q_valid |-> r_idx < i_head.count, "unpack index beyond packet")
    `B64D_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !r_valid && r_idx == 2'd0, "back end not idle after reset")

endmodule

FILE: rtl/core/base64_stream_decoder_core.sv
// top level of the base64 stream decoder
//
// Streaming base64 decoder. One character is taken per word on the input
// channel (valid/stall); decoded bytes and error codes leave one per word on the
// output channel, with last_of_run marking the final word caused by a character.
// A character is accepted every cycle while the packet queue has room; a full
// quartet yields three output words, so a run of quartets is paced by the output
// register, which sends one word per cycle unless the receiver stalls; the front
// end stalls once the queue (QUEUE_DEPTH packets) fills. Packets pass through the
// queue, then the output register. Errors are sticky until reset. The user must
// write comment_limit through i_cfg_we / i_cfg_wdata only while idle (unchecked).
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: comment_limit
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    // character input
    input  logic                i_valid,
    output logic                o_stall,
    input  b64d_pkg::t_in_word  i_word,
    // decoded output
    output logic                o_valid,
    input  logic                i_stall,
    output b64d_pkg::t_out_word o_word
);
    import b64d_pkg::*;

    // packet handoff between front and back
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_pkt push_pkt;
    t_pkt head_pkt;

    // front end: per-character decode, one character per cycle while the queue has room
    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_pkt       (push_pkt)
    );

    // queue lets the front keep accepting while the back drains multi-byte packets
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_pkt)
    );

    // back end: one output word per cycle into the output register unless the receiver stalls
    b64d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head_pkt),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_word    (o_word)
    );

endmodule

FILE: tb/tb_base64_stream_decoder_core.sv
// self-checking testbench for the base64 stream decoder core
`timescale 1ns / 100ps

module tb_base64_stream_decoder_core;
    import b64d_pkg::*;

    localparam logic [7:0] CH_RETURN = 8'h0D;

    // ways the single stream of the run is brought to its end
    typedef enum int {
        END_BAD_CHAR,
        END_EARLY_PAD,
        END_DATA_AFTER_PAD,
        END_ONE_BYTE,
        END_TWO_BYTES,
        END_DASH_MID_QUARTET,
        END_DASH_IN_COMMENT,
        END_LONG_COMMENT,
        END_TRUNCATED,
        END_CLEAN,
        END_IN_COMMENT,
        END_BAD_CHAR_AT_EOS,
        END_NEWLINE_AT_EOS
    } t_stream_end;

    // one directed character, with its bytes typed in where they are obvious
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic [1:0]  n_bytes;
        logic [23:0] bytes;
    } t_directed_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    base64_stream_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

    // decoder state as the testbench sees it
    logic [7:0]  cmt_limit = 8'd75;   // reset value of the comment limit
    logic [1:0]  q_pos;
    logic [17:0] acc;
    logic [1:0]  pad_cnt;
    logic        cmt_open;
    logic [7:0]  cmt_len;
    logic        sticky_err;
    logic        done_flag;

    t_out_word char_results[$];   // words caused by the character just accepted
    t_out_word awaited_words[$];  // words predicted but not yet seen on the output
    t_out_word oldest_word;
    bit        mismatch_seen;

    int sender_idle_pct;
    int receiver_stall_pct;

    t_directed_row directed_rows [25];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous bound on the whole run
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver side: stall decided at each falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // output check: each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected word: data_byte %0h status %0d last_of_run %0b",
                       o_word.data_byte, o_word.status, o_word.last_of_run);
                mismatch_seen = 1'b1;
            end else begin
                oldest_word = awaited_words.pop_front();
                if (o_word.data_byte !== oldest_word.data_byte) begin
                    $error("data_byte: expected %0h, got %0h",
                           oldest_word.data_byte, o_word.data_byte);
                    mismatch_seen = 1'b1;
                end
                if (o_word.status !== oldest_word.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_word.status, o_word.status);
                    mismatch_seen = 1'b1;
                end
                if (o_word.last_of_run !== oldest_word.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           oldest_word.last_of_run, o_word.last_of_run);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // base64 alphabet lookup, bit 6 set for anything outside it
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
        if (c == CH_PLUS) return 7'd62;
        if (c == CH_SLASH) return 7'd63;
        return 7'd64;
    endfunction

    task automatic add_result(input logic [7:0] b, input t_status s);
        char_results.insert(char_results.size(),
                            t_out_word'{data_byte: b, status: s, last_of_run: 1'b0});
    endtask

    task automatic raise_error(input t_status s);
        add_result(8'h00, s);
        sticky_err = 1'b1;
    endtask

    task automatic restart_quartet();
        q_pos   = 2'd0;
        acc     = 18'd0;
        pad_cnt = 2'd0;
    endtask

    // predicted words of one character, left in char_results
    task automatic decode_char(input logic [7:0] c, input logic eos);
        logic [6:0]  v;
        logic [23:0] full;
        logic [8:0]  next_len;

        if (sticky_err) return;

        if (done_flag) begin
            // only newlines may trail a padded quartet
            if (pad_cnt != 2'd0 && c != CH_NEWLINE) raise_error(ST_PADDING);
        end else if (cmt_open) begin
            if (c == CH_NEWLINE) begin
                cmt_open = 1'b0;
                cmt_len  = 8'd0;
            end else if (c == CH_DASH) begin
                raise_error(ST_COMMENT_DASH);
            end else begin
                next_len = {1'b0, cmt_len} + 9'd1;
                if (next_len > {1'b0, cmt_limit}) raise_error(ST_COMMENT_LONG);
                cmt_len = next_len[8] ? 8'hFF : next_len[7:0];
            end
        end else if (c == CH_NEWLINE) begin
            // skipped
        end else if (c == CH_DASH) begin
            if (q_pos == 2'd0) begin
                cmt_open = 1'b1;
                cmt_len  = 8'd0;
            end else begin
                raise_error(ST_INVALID);
            end
        end else if (c == CH_PAD) begin
            if (q_pos < 2'd2) begin
                raise_error(ST_PADDING);
            end else if (q_pos == 2'd2) begin
                pad_cnt = 2'd1;
                q_pos   = 2'd3;
            end else if (pad_cnt != 2'd0) begin
                // two sextets held: one byte, low four bits dropped
                add_result(acc[11:4], ST_BYTE);
                restart_quartet();
                pad_cnt   = 2'd2;
                done_flag = 1'b1;
            end else begin
                // three sextets held: two bytes, low two bits dropped
                add_result(acc[17:10], ST_BYTE);
                add_result(acc[9:2], ST_BYTE);
                restart_quartet();
                pad_cnt   = 2'd1;
                done_flag = 1'b1;
            end
        end else begin
            v = char_to_sextet(c);
            if (v[6]) begin
                raise_error(ST_INVALID);
            end else if (pad_cnt != 2'd0) begin
                raise_error(ST_PADDING);
            end else if (q_pos < 2'd3) begin
                acc   = {acc[11:0], v[5:0]};
                q_pos = q_pos + 2'd1;
            end else begin
                full = {acc, v[5:0]};
                add_result(full[23:16], ST_BYTE);
                add_result(full[15:8], ST_BYTE);
                add_result(full[7:0], ST_BYTE);
                restart_quartet();
            end
        end

        // end of stream closes any comment and flags a half-filled quartet
        if (eos && !sticky_err && !done_flag) begin
            cmt_open = 1'b0;
            cmt_len  = 8'd0;
            if (q_pos != 2'd0) raise_error(ST_TRUNCATED);
            done_flag = 1'b1;
        end

        if (char_results.size() > 0) begin
            char_results[char_results.size() - 1].last_of_run = 1'b1;
        end
    endtask

    // present one word, hold it until accepted, then record its predicted words
    task automatic send_char(input logic [7:0] ch, input logic eos = 1'b0,
                             input logic typed = 1'b0, input logic [1:0] n_typed = 2'd0,
                             input logic [23:0] typed_bytes = 24'd0);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= t_in_word'{char_in: ch, end_of_stream: eos};
        do @(posedge i_clk); while (o_stall);

        decode_char(ch, eos);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                awaited_words.insert(awaited_words.size(),
                                     t_out_word'{data_byte: typed_bytes[8*(2-k) +: 8],
                                                 status: ST_BYTE,
                                                 last_of_run: (k == n_typed - 1)});
            end
        end else begin
            foreach (char_results[k]) awaited_words.insert(awaited_words.size(),
                                                           char_results[k]);
        end
        char_results.delete();
    endtask

    function automatic logic [7:0] random_data_char();
        int v;
        v = $urandom_range(0, 63);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? CH_PLUS : CH_SLASH;
    endfunction

    // any byte that keeps a comment open
    function automatic logic [7:0] random_comment_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE || c == CH_DASH);
        return c;
    endfunction

    // a byte outside the alphabet and the control characters, often a return
    function automatic logic [7:0] random_junk_char();
        logic [7:0] c;
        logic [6:0] v;
        if ($urandom_range(0, 1) == 0) return CH_RETURN;
        do begin
            c = 8'($urandom_range(0, 255));
            v = char_to_sextet(c);
        end while (!v[6] || c == CH_NEWLINE || c == CH_DASH || c == CH_PAD);
        return c;
    endfunction

    task automatic send_data_chars(input int n);
        repeat (n) send_char(random_data_char());
    endtask

    // quartets, comments and blank lines with random content, ending on a boundary
    task automatic send_well_formed(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int k = 0; k < 4; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_char(CH_NEWLINE);
                        sent++;
                    end
                    send_char(random_data_char());
                    sent++;
                end
            end else if (pick < 88) begin
                // now and then a comment exactly at a small limit
                if (cmt_limit <= 8'd16 && $urandom_range(0, 7) == 0) begin
                    len = int'(cmt_limit);
                end else begin
                    len = $urandom_range(0, (cmt_limit < 8'd12) ? int'(cmt_limit) : 12);
                end
                send_char(CH_DASH);
                repeat (len) send_char(random_comment_char());
                send_char(CH_NEWLINE);
                sent += len + 2;
            end else begin
                send_char(CH_NEWLINE);
                sent++;
            end
        end
    endtask

    // drop valid and let every predicted word come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_comment_limit(input logic [7:0] value);
        drain_results();
        // words with no result may still be in the pipe
        repeat (6) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cmt_limit = value;
    endtask

    // the stream ends once per reset, so one random ending is picked per run
    task automatic finish_stream();
        t_stream_end how;
        how = t_stream_end'($urandom_range(0, 12));
        case (how)
            END_BAD_CHAR: begin
                send_data_chars($urandom_range(0, 3));
                send_char(random_junk_char());
            end
            END_EARLY_PAD: begin
                send_data_chars($urandom_range(0, 1));
                send_char(CH_PAD);
            end
            END_DATA_AFTER_PAD: begin
                send_data_chars(2);
                send_char(CH_PAD);
                send_char(random_data_char());
            end
            END_ONE_BYTE: begin
                send_data_chars(2);
                send_char(CH_PAD);
                send_char(CH_PAD);
                send_char(CH_NEWLINE);
            end
            END_TWO_BYTES: begin
                send_data_chars(3);
                send_char(CH_PAD);
            end
            END_DASH_MID_QUARTET: begin
                send_data_chars($urandom_range(1, 3));
                send_char(CH_DASH);
            end
            END_DASH_IN_COMMENT: begin
                send_char(CH_DASH);
                repeat ($urandom_range(0, 4)) send_char(random_comment_char());
                send_char(CH_DASH);
            end
            END_LONG_COMMENT: begin
                send_char(CH_DASH);
                repeat (int'(cmt_limit) + 1) send_char(random_comment_char());
            end
            END_TRUNCATED: begin
                send_data_chars($urandom_range(0, 2));
                send_char(random_data_char(), 1'b1);
            end
            END_CLEAN: begin
                send_data_chars(3);
                send_char(random_data_char(), 1'b1);
            end
            END_IN_COMMENT: begin
                send_char(CH_DASH);
                repeat ($urandom_range(0, 4)) send_char(random_comment_char());
                send_char(random_comment_char(), 1'b1);
            end
            END_BAD_CHAR_AT_EOS: begin
                send_data_chars($urandom_range(1, 3));
                send_char(random_junk_char(), 1'b1);
            end
            default: begin
                send_data_chars($urandom_range(0, 3));
                send_char(CH_NEWLINE, 1'b1);
            end
        endcase
        // trailing noise: ignored, or an error after a padded end
        repeat (16) begin
            if ($urandom_range(0, 3) == 0) begin
                send_char(CH_NEWLINE, 1'($urandom_range(0, 1)));
            end else begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'd0;
        i_valid            = 1'b0;
        i_word             = '0;
        i_stall            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_seen      = 1'b0;
        restart_quartet();
        cmt_open   = 1'b0;
        cmt_len    = 8'd0;
        sticky_err = 1'b0;
        done_flag  = 1'b0;

        // alphabet extremes, comment with odd bytes, newline inside a quartet
        directed_rows = '{
            '{CH_UP_A,    1'b1, 2'd0, 24'h000000},
            '{CH_UP_A,    1'b1, 2'd0, 24'h000000},
            '{CH_UP_A,    1'b1, 2'd0, 24'h000000},
            '{CH_UP_A,    1'b1, 2'd3, 24'h000000},
            '{CH_SLASH,   1'b1, 2'd0, 24'h000000},
            '{CH_SLASH,   1'b1, 2'd0, 24'h000000},
            '{CH_SLASH,   1'b1, 2'd0, 24'h000000},
            '{CH_SLASH,   1'b1, 2'd3, 24'hFFFFFF},
            '{CH_NEWLINE, 1'b1, 2'd0, 24'h000000},
            '{CH_DASH,    1'b1, 2'd0, 24'h000000},
            '{8'h00,      1'b0, 2'd0, 24'h000000},
            '{8'hFF,      1'b0, 2'd0, 24'h000000},
            '{CH_PAD,     1'b0, 2'd0, 24'h000000},
            '{CH_NEWLINE, 1'b0, 2'd0, 24'h000000},
            '{"T",        1'b0, 2'd0, 24'h000000},
            '{"W",        1'b0, 2'd0, 24'h000000},
            '{"F",        1'b0, 2'd0, 24'h000000},
            '{"u",        1'b0, 2'd0, 24'h000000},
            '{CH_LO_Z,    1'b0, 2'd0, 24'h000000},
            '{CH_NEWLINE, 1'b0, 2'd0, 24'h000000},
            '{CH_DIG_9,   1'b0, 2'd0, 24'h000000},
            '{CH_PLUS,    1'b0, 2'd0, 24'h000000},
            '{CH_DIG_0,   1'b0, 2'd0, 24'h000000},
            '{CH_DASH,    1'b0, 2'd0, 24'h000000},
            '{CH_NEWLINE, 1'b0, 2'd0, 24'h000000}
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at full rate with the reset limit
        foreach (directed_rows[r]) begin
            send_char(directed_rows[r].ch, 1'b0, directed_rows[r].typed,
                      directed_rows[r].n_bytes, directed_rows[r].bytes);
        end

        // smallest limit, sparse sender
        write_comment_limit(8'd1);
        sender_idle_pct = 83;
        send_well_formed(35);

        // largest limit, receiver mostly stalled
        write_comment_limit(8'd255);
        sender_idle_pct    = 0;
        receiver_stall_pct = 83;
        send_well_formed(35);

        // random limit, both sides idle now and then
        write_comment_limit(8'($urandom_range(2, 40)));
        sender_idle_pct    = 34;
        receiver_stall_pct = 34;
        send_well_formed(35);

        finish_stream();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (!mismatch_seen) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
